// ===== hdl/crp_pkg.sv =====
// Shared constants and types of the A1 cell reference parser.
`timescale 1ns / 1ps

package crp_pkg;

    localparam int MAX_COL_LETTERS = 5;
    localparam int MAX_ROW_DIGITS  = 7;

    localparam int CHAR_W = 8;
    localparam int ACC_W  = 24;
    localparam int COL_W  = 24;
    localparam int ROW_W  = 25;
    localparam int LC_W   = $clog2(MAX_COL_LETTERS + 1);
    localparam int DC_W   = $clog2(MAX_ROW_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CHAR_UA     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UZ     = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LA     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LZ     = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [ACC_W-1:0] col_accum;
        logic [ACC_W-1:0] row_accum;
        logic [LC_W-1:0]  letter_count;
        logic [DC_W-1:0]  digit_count;
        logic             error_seen;
    } parse_state_t;

    localparam parse_state_t PARSE_STATE_CLEAR = '0;

endpackage

// ===== hdl/crp_if.sv =====
// Valid/ready channel interfaces for characters and parsed results.
`timescale 1ns / 1ps

interface crp_char_if;
    logic                       valid;
    logic                       ready;
    logic [crp_pkg::CHAR_W-1:0] char_code;
    logic                       last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface crp_result_if;
    logic                             valid;
    logic                             ready;
    logic        [crp_pkg::COL_W-1:0] col_index;
    logic signed [crp_pkg::ROW_W-1:0] row_index;
    logic                             ok;

    modport source (output valid, output col_index, output row_index, output ok,
                    input ready);
    modport sink   (input valid, input col_index, input row_index, input ok,
                    output ready);
endinterface

// ===== hdl/crp_step.sv =====
// Next parse state for one character of a cell reference.
`timescale 1ns / 1ps

module crp_step (
    input  logic [crp_pkg::CHAR_W-1:0] char_code,
    input  crp_pkg::parse_state_t      cur,
    output crp_pkg::parse_state_t      nxt
);
    import crp_pkg::*;

    localparam logic [LC_W-1:0] LC_MAX = LC_W'(MAX_COL_LETTERS);
    localparam logic [DC_W-1:0] DC_MAX = DC_W'(MAX_ROW_DIGITS);

    logic [CHAR_W-1:0] upper;
    logic [ACC_W-1:0]  digit_val;
    logic [ACC_W-1:0]  letter_val;

    always_comb
    begin
        // fold lower case; codes above 7F are left alone
        if (char_code inside {[CHAR_LA:CHAR_LZ]})
            upper = char_code - CASE_OFFSET;
        else
            upper = char_code;

        digit_val  = ACC_W'(upper - CHAR_0);
        letter_val = ACC_W'(upper - CHAR_UA) + ACC_W'(1);

        nxt = cur;
        if (!cur.error_seen && char_code != CHAR_DOLLAR)
        begin
            if (upper inside {[CHAR_0:CHAR_9]})
            begin
                if (cur.letter_count == '0 || cur.digit_count >= DC_MAX)
                    nxt.error_seen = 1'b1;
                else
                begin
                    nxt.row_accum   = cur.row_accum * ACC_W'(10) + digit_val;
                    nxt.digit_count = cur.digit_count + DC_W'(1);
                end
            end
            else if (upper inside {[CHAR_UA:CHAR_UZ]})
            begin
                if (cur.digit_count != '0 || cur.letter_count >= LC_MAX)
                    nxt.error_seen = 1'b1;
                else
                begin
                    nxt.col_accum    = cur.col_accum * ACC_W'(26) + letter_val;
                    nxt.letter_count = cur.letter_count + LC_W'(1);
                end
            end
            else
                nxt.error_seen = 1'b1;
        end
    end

endmodule

// ===== hdl/cell_reference_parser.sv =====
// Top level of the A1 cell reference parser.
// The transfer of the last character loads the input register; the state update then loads
// the result register, which frees as it is taken, and the result becomes valid.
// Throughput: one character per cycle; a final character waits for a free result register.
// rst_n clears the pipeline valids and the parse state; a reference starts afresh.
`timescale 1ns / 1ps

module cell_reference_parser (
    input  logic         clk,
    input  logic         rst_n,
    crp_char_if.sink     chars,
    crp_result_if.source results
);
    import crp_pkg::*;

    logic              s1_valid_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_last_reg;

    parse_state_t state_reg;
    parse_state_t state_next;

    logic                    out_valid_reg;
    logic [COL_W-1:0]        out_col_reg;
    logic signed [ROW_W-1:0] out_row_reg;
    logic                    out_ok_reg;

    logic                    out_free;
    logic                    s1_advance;
    logic                    emit;
    logic [COL_W-1:0]        col_next;
    logic signed [ROW_W-1:0] row_next;

    crp_step u_step (
        .char_code (s1_char_reg),
        .cur       (state_reg),
        .nxt       (state_next)
    );

    assign out_free    = !out_valid_reg || results.ready;
    // a non-final character never needs the result register
    assign s1_advance  = s1_valid_reg && (!s1_last_reg || out_free);
    assign emit        = s1_advance && s1_last_reg;
    assign chars.ready = !s1_valid_reg || s1_advance;

    always_comb
    begin
        col_next = '0;
        row_next = '0;
        if (!state_next.error_seen)
        begin
            if (state_next.letter_count != '0)
                col_next = COL_W'(state_next.col_accum - ACC_W'(1));
            if (state_next.digit_count != '0)
                row_next = ROW_W'({1'b0, state_next.row_accum}) - ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= PARSE_STATE_CLEAR;
        end
        else
        begin
            if (chars.ready)
                s1_valid_reg <= chars.valid;
            if (s1_advance)
                state_reg <= s1_last_reg ? PARSE_STATE_CLEAR : state_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            s1_char_reg <= chars.char_code;
            s1_last_reg <= chars.last;
        end
        if (emit)
        begin
            out_col_reg <= col_next;
            out_row_reg <= row_next;
            out_ok_reg  <= !state_next.error_seen;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.col_index = out_col_reg;
    assign results.row_index = out_row_reg;
    assign results.ok        = out_ok_reg;

endmodule

// ===== hdl/crp_checker.sv =====
// Port-level checks on the cell reference parser, bound to the top level.
`timescale 1ns / 1ps

module crp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             res_valid,
    input logic                             res_ready,
    input logic        [crp_pkg::COL_W-1:0] res_col,
    input logic signed [crp_pkg::ROW_W-1:0] res_row,
    input logic                             res_ok
);
    import crp_pkg::*;

    // a stalled result must hold
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_col)
            && $stable(res_row) && $stable(res_ok))
        else $error("result changed while stalled");

    // failed parses report zero indices
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ok |-> res_col == '0 && res_row == '0)
        else $error("error result with non-zero indices");

    // the only negative row is row zero, reported as minus one
    a_row_floor: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_row[ROW_W-1] |-> res_row == -ROW_W'(1) && res_ok)
        else $error("row index below minus one");

endmodule

bind cell_reference_parser crp_checker u_crp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_col   (results.col_index),
    .res_row   (results.row_index),
    .res_ok    (results.ok)
);
